FILE: rtl/spectral_gate_gain_smoother_defines.svh
// Assertion macros for the spectral gate gain smoother.
// Used by the modules that check their own control logic; expects clk and rst in scope.
`ifndef SPECTRAL_GATE_GAIN_SMOOTHER_DEFINES_SVH
`define SPECTRAL_GATE_GAIN_SMOOTHER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset
`define SGG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgg assertion failed");
// Next-cycle implication
`define SGG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgg assertion failed");
`else
`define SGG_ASSERT_NOW(lbl, ante, cons)
`define SGG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/sgg_pkg.sv
// Shared types and constants for the spectral gate gain smoother.
// No dependencies; imported by sgg_front, sgg_back and the top level.
package sgg_pkg;

  localparam int BIN_W   = 9;
  localparam int FIELD_W = 32;
  localparam int SQ_W    = 64;
  localparam int THR_W   = 63;
  localparam int GAIN_W  = 23;
  localparam int SPEED_W = 17;
  localparam int OUT_W   = 16;
  localparam int Q_SHIFT = 16;
  localparam int OUT_SHIFT = 7;
  localparam int NUM_FIELDS = 4;

  localparam logic [GAIN_W-1:0]  UNITY_Q16 = GAIN_W'(65536);
  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(65536);
  localparam logic [OUT_W-1:0]   BIN0_GAIN = OUT_W'(65536 >> 7);

  // Queue depths between the halves and at the result side
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_THRESHOLD = 3'd0,
    REG_BELOW_GAIN      = 3'd1,
    REG_ABOVE_GAIN      = 3'd2,
    REG_BAND_LOW_BIN    = 3'd3,
    REG_BAND_HIGH_BIN   = 3'd4,
    REG_SMOOTH_SPEED    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [BIN_W-1:0]          bin_index;
    logic signed [FIELD_W-1:0] right_re;
    logic signed [FIELD_W-1:0] right_im;
    logic signed [FIELD_W-1:0] left_re;
    logic signed [FIELD_W-1:0] left_im;
  } sample_t;

  typedef struct packed {
    logic [OUT_W-1:0] gain_out;
    logic [BIN_W-1:0] bin_out;
  } result_t;

  typedef struct packed {
    logic [THR_W-1:0]   power_threshold;
    logic [GAIN_W-1:0]  below_gain;
    logic [GAIN_W-1:0]  above_gain;
    logic [BIN_W-1:0]   band_low_bin;
    logic [BIN_W-1:0]   band_high_bin;
    logic [SPEED_W-1:0] smooth_speed;
  } cfg_t;

  // Classified bin handed from the front to the back
  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic              in_range;
    logic              is_zero;
    logic [GAIN_W-1:0] target;
  } mid_t;

endpackage

FILE: rtl/sgg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgg_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sgg_fifo.sv
// Small synchronous FIFO with show-ahead output.
// No dependencies; push while full is allowed only together with a pop.
module sgg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign dout  = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/sgg_front.sv
// Front half: takes bins, classifies them against the band and computes the
// summed channel power over four stages, then picks the target gain. Uses sgg_pkg.
module sgg_front
  import sgg_pkg::*;
#(
  parameter int LAST_BIN = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    accept,
  input  sample_t sample,
  input  logic    mid_pop,
  output logic    mid_push,
  output mid_t    mid_item,
  output logic    full
);

  localparam int AW = $clog2(LAST_BIN + 1);
  localparam int CW = AW + BIN_W;
  localparam int OCC_W = $clog2(MID_DEPTH + 1);

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             in_range;
    logic             is_zero;
    logic             gated;
  } cls_t;

  // Stage 1: raw word
  logic                               f1_v;
  logic [BIN_W-1:0]                   f1_bin;
  logic [NUM_FIELDS-1:0][FIELD_W-1:0] f1_raw;
  // Stage 2: squares
  logic                               f2_v;
  cls_t                               f2_cls;
  logic [SQ_W-1:0]                    f2_sq [NUM_FIELDS];
  // Stage 3: pair sums
  logic                               f3_v;
  cls_t                               f3_cls;
  logic [SQ_W-1:0]                    f3_sum_r;
  logic [SQ_W-1:0]                    f3_sum_l;
  // Stage 4: total power
  logic                               f4_v;
  cls_t                               f4_cls;
  logic [SQ_W-1:0]                    f4_power;

  logic [OCC_W-1:0]                   occ;
  cls_t                               f1_cls;
  logic [FIELD_W-1:0]                 f1_mag [NUM_FIELDS];
  logic [CW-1:0]                      bin_ext;
  logic [CW-1:0]                      band_lo;
  logic [CW-1:0]                      band_hi;
  logic [CW-1:0]                      last_ext;

  // Clamp the band and classify the bin
  always_comb begin
    last_ext = CW'(LAST_BIN);
    bin_ext  = CW'(f1_bin);
    band_lo  = (cfg.band_low_bin == '0) ? CW'(1) : CW'(cfg.band_low_bin);
    band_hi  = (CW'(cfg.band_high_bin) > last_ext) ? last_ext : CW'(cfg.band_high_bin);
    f1_cls.bin      = f1_bin;
    f1_cls.in_range = (bin_ext <= last_ext);
    f1_cls.is_zero  = (f1_bin == '0);
    f1_cls.gated    = (f1_bin != '0) && (bin_ext >= band_lo) && (bin_ext <= band_hi);
  end

  // Take the magnitude of each two's complement part
  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      f1_mag[i] = f1_raw[i][FIELD_W-1] ? (~f1_raw[i] + 1'b1) : f1_raw[i];
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_bin    <= sample.bin_index;
      f1_raw[0] <= sample.right_re;
      f1_raw[1] <= sample.right_im;
      f1_raw[2] <= sample.left_re;
      f1_raw[3] <= sample.left_im;
    end
    f2_cls <= f1_cls;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      f2_sq[i] <= SQ_W'(f1_mag[i]) * SQ_W'(f1_mag[i]);
    end
    f3_cls   <= f2_cls;
    f3_sum_r <= f2_sq[0] + f2_sq[1];
    f3_sum_l <= f2_sq[2] + f2_sq[3];
    f4_cls   <= f3_cls;
    f4_power <= f3_sum_r + f3_sum_l;
  end

  // Valid bits and queue credit: items in flight plus items waiting in the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      f4_v <= 1'b0;
      occ  <= '0;
    end else begin
      f1_v <= accept;
      f2_v <= f1_v;
      f3_v <= f2_v;
      f4_v <= f3_v;
      if (accept && !mid_pop) begin
        occ <= occ + 1'b1;
      end else if (mid_pop && !accept) begin
        occ <= occ - 1'b1;
      end
    end
  end

  assign full = (occ == OCC_W'(MID_DEPTH));

  // Pick the target gain
  always_comb begin
    mid_push          = f4_v;
    mid_item.bin      = f4_cls.bin;
    mid_item.in_range = f4_cls.in_range;
    mid_item.is_zero  = f4_cls.is_zero;
    priority if (f4_cls.is_zero) begin
      mid_item.target = UNITY_Q16;
    end else if (f4_cls.gated) begin
      mid_item.target = (f4_power < SQ_W'(cfg.power_threshold)) ? cfg.below_gain
                                                                 : cfg.above_gain;
    end else begin
      mid_item.target = '0;
    end
  end

endmodule

FILE: rtl/sgg_back.sv
// Back half: sweeps the gain history to unity after reset, then reads, smooths and
// writes back one history entry per in-range bin. Uses sgg_pkg, sgg_ram and the assertion macros.
`include "spectral_gate_gain_smoother_defines.svh"

module sgg_back
  import sgg_pkg::*;
#(
  parameter int LAST_BIN = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  mid_t    mid_item,
  input  logic    mid_empty,
  output logic    mid_pop,
  input  logic    out_ready,
  output logic    out_push,
  output result_t out_item,
  output logic    clr_busy
);

  localparam int AW = $clog2(LAST_BIN + 1);

  logic                       s1_valid;
  mid_t                       s1_item;
  logic                       s1_adv;
  logic [AW-1:0]              s1_addr;
  logic [AW-1:0]              clr_addr;
  logic                       lw_valid;
  logic [AW-1:0]              lw_addr;
  logic [GAIN_W-1:0]          lw_data;
  logic [GAIN_W-1:0]          ram_rdata;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [GAIN_W-1:0]          ram_wdata;
  logic [GAIN_W-1:0]          his_sel;
  logic [SPEED_W-1:0]         speed_sat;
  logic signed [GAIN_W:0]     diff;
  logic signed [SPEED_W:0]    speed_s;
  logic signed [GAIN_W+SPEED_W+1:0] prod;
  logic [GAIN_W-1:0]          new_his;

  sgg_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (LAST_BIN + 1)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (mid_pop),
    .raddr (AW'(mid_item.bin)),
    .rdata (ram_rdata)
  );

  // Advance when the result queue can take the word
  assign s1_adv  = s1_valid && out_ready;
  assign mid_pop = !mid_empty && !clr_busy && (!s1_valid || out_ready);
  assign s1_addr = AW'(s1_item.bin);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (mid_pop) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_item <= mid_item;
    end
  end

  // Sweep every history entry to unity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(LAST_BIN)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Forward the latest write when it hits the entry just read
  assign his_sel = (lw_valid && lw_addr == s1_addr) ? lw_data : ram_rdata;

  // Move the history toward the target; the arithmetic shift floors the step
  always_comb begin
    speed_sat = (cfg.smooth_speed > SPEED_MAX) ? SPEED_MAX : cfg.smooth_speed;
    speed_s   = $signed({1'b0, speed_sat});
    diff      = $signed({1'b0, s1_item.target}) - $signed({1'b0, his_sel});
    prod      = diff * speed_s;
    new_his   = his_sel + prod[Q_SHIFT +: GAIN_W];
  end

  // History write: sweep first, then smoothed values of in-range bins
  always_comb begin
    ram_we    = clr_busy || (s1_adv && s1_item.in_range);
    ram_waddr = clr_busy ? clr_addr : s1_addr;
    ram_wdata = clr_busy ? UNITY_Q16 : new_his;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (clr_busy) begin
      lw_valid <= 1'b0;
    end else if (s1_adv && s1_item.in_range) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.in_range) begin
      lw_addr <= s1_addr;
      lw_data <= new_his;
    end
  end

  // Result word
  always_comb begin
    out_push         = s1_adv;
    out_item.bin_out = s1_item.bin;
    priority if (!s1_item.in_range) begin
      out_item.gain_out = '0;
    end else if (s1_item.is_zero) begin
      out_item.gain_out = BIN0_GAIN;
    end else begin
      out_item.gain_out = new_his[OUT_SHIFT +: OUT_W];
    end
  end

  `SGG_ASSERT_NEXT(a_stall_holds, s1_valid && !out_ready, s1_valid && $stable(s1_item))
  `SGG_ASSERT_NOW(a_sweep_covers_all, $fell(clr_busy), $past(clr_addr) == AW'(LAST_BIN))
  `SGG_ASSERT_NOW(a_no_write_out_of_range, s1_adv && !s1_item.in_range, !ram_we)
  `SGG_ASSERT_NOW(a_no_pop_in_sweep, clr_busy, !mid_pop && !s1_valid)

endmodule

FILE: rtl/spectral_gate_gain_smoother.sv
// Channel   Handshake              Word
// sample    push / full            bin_index, right_re, right_im, left_re, left_im
// result    pop / empty            gain_out, bin_out
// config    cfg_wr_en, cfg_index   cfg_data (widest register, 63 bits)
//
// One bin per cycle sustained while full stays low. A bin passes the front
// stages f1 to f4 into the classified-bin queue, then s1 and the result queue.
// After reset the history memory is swept to unity with full held high;
// configuration writes are taken during the sweep.
// A stalled result side fills the result and classified-bin queues; full rises
// once eight bins are in the front stages and the queue together.
// Top level of the spectral gate gain smoother. Uses sgg_pkg, sgg_front,
// sgg_back and sgg_fifo.
`include "spectral_gate_gain_smoother_defines.svh"

module spectral_gate_gain_smoother
  import sgg_pkg::*;
#(
  parameter int LAST_BIN = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  sample_t              sample,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  cfg_t    cfg;
  logic    accept;
  logic    front_full;
  logic    clr_busy;
  logic    mid_push;
  mid_t    mid_in;
  mid_t    mid_out;
  logic    mid_pop;
  logic    mid_empty;
  logic    mid_full;
  logic    out_push;
  result_t out_in;
  logic    out_full;
  logic    out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_threshold <= '0;
      cfg.below_gain      <= '0;
      cfg.above_gain      <= UNITY_Q16;
      cfg.band_low_bin    <= '0;
      cfg.band_high_bin   <= BIN_W'(256);
      cfg.smooth_speed    <= SPEED_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POWER_THRESHOLD: cfg.power_threshold <= cfg_data;
        REG_BELOW_GAIN:      cfg.below_gain      <= cfg_data[GAIN_W-1:0];
        REG_ABOVE_GAIN:      cfg.above_gain      <= cfg_data[GAIN_W-1:0];
        REG_BAND_LOW_BIN:    cfg.band_low_bin    <= cfg_data[BIN_W-1:0];
        REG_BAND_HIGH_BIN:   cfg.band_high_bin   <= cfg_data[BIN_W-1:0];
        REG_SMOOTH_SPEED:    cfg.smooth_speed    <= cfg_data[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign full      = front_full || clr_busy;
  assign accept    = push && !full;
  assign out_ready = !out_full || (pop && !empty);

  sgg_front #(
    .LAST_BIN (LAST_BIN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .sample   (sample),
    .mid_pop  (mid_pop),
    .mid_push (mid_push),
    .mid_item (mid_in),
    .full     (front_full)
  );

  sgg_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_in),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty),
    .full  (mid_full)
  );

  sgg_back #(
    .LAST_BIN (LAST_BIN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_item  (mid_out),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_ready (out_ready),
    .out_push  (out_push),
    .out_item  (out_in),
    .clr_busy  (clr_busy)
  );

  sgg_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_in),
    .pop   (pop && !empty),
    .dout  (result),
    .empty (empty),
    .full  (out_full)
  );

  `SGG_ASSERT_NOW(a_mid_never_overflows, mid_push && mid_full, mid_pop)

endmodule

FILE: dv/spectral_gate_gain_smoother_test.sv
// Self-checking testbench for the spectral gate gain smoother.
// Directed and random bins against an in-bench gain predictor; needs sgg_pkg and the block's RTL.
module spectral_gate_gain_smoother_test
  import sgg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAST_BIN = 256;
  localparam logic [31:0] FIELD_MIN = 32'h8000_0000;
  localparam logic [31:0] FIELD_MAX = 32'h7FFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  sample_t              in_word = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  result_t              out_word;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;

  // Predictor copy of the settings and the per-bin history
  logic [THR_W-1:0]   thr_q;
  logic [GAIN_W-1:0]  below_q;
  logic [GAIN_W-1:0]  above_q;
  logic [BIN_W-1:0]   band_lo_q;
  logic [BIN_W-1:0]   band_hi_q;
  logic [SPEED_W-1:0] speed_q;
  logic [GAIN_W-1:0]  gain_track [0:LAST_BIN];

  result_t expected_gains [$];
  result_t want_word;
  int      mismatch_count = 0;
  bit      idle_on = 1'b1;
  int      pop_hold = 0;

  spectral_gate_gain_smoother #(.LAST_BIN(LAST_BIN)) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .sample(in_word),
    .empty(empty),
    .pop(pop),
    .result(out_word),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Squared magnitude of one signed part, 64 bits
  function automatic logic [63:0] mag_sq(input logic [31:0] v);
    logic [63:0] m;
    m = {32'b0, v};
    if (v[31]) m = 64'h1_0000_0000 - m;
    return m * m;
  endfunction

  // Predict the gain word for one bin and advance the history
  function automatic result_t predict_gain(input sample_t s);
    result_t     r;
    logic [8:0]  b;
    logic [8:0]  lo;
    logic [8:0]  hi;
    logic [22:0] tgt;
    logic [22:0] his;
    logic [63:0] pwr;
    longint      tgt_l;
    longint      his_l;
    longint      spd_l;
    longint      stepv;
    b = s.bin_index;
    r.bin_out = b;
    r.gain_out = '0;
    if (b > LAST_BIN) return r;
    lo = (band_lo_q < 1) ? 9'd1 : band_lo_q;
    hi = (band_hi_q > LAST_BIN) ? 9'(LAST_BIN) : band_hi_q;
    if (b == 0) begin
      tgt = UNITY_Q16;
    end else if (b >= lo && b <= hi) begin
      pwr = mag_sq(s.right_re) + mag_sq(s.right_im) + mag_sq(s.left_re) + mag_sq(s.left_im);
      tgt = (pwr < {1'b0, thr_q}) ? below_q : above_q;
    end else begin
      tgt = '0;
    end
    spd_l = longint'((speed_q > SPEED_MAX) ? SPEED_MAX : speed_q);
    his = gain_track[b];
    tgt_l = longint'(tgt);
    his_l = longint'(his);
    stepv = ((tgt_l - his_l) * spd_l) >>> 16;
    his = his + stepv[22:0];
    gain_track[b] = his;
    r.gain_out = (b == 0) ? BIN0_GAIN : his[22:7];
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic sample_t make_bin(input logic [8:0] b, input logic [31:0] rr,
                                       input logic [31:0] ri, input logic [31:0] lr,
                                       input logic [31:0] li);
    sample_t s;
    s.bin_index = b;
    s.right_re = rr;
    s.right_im = ri;
    s.left_re = lr;
    s.left_im = li;
    return s;
  endfunction

  // One spectral part at the chosen scale
  function automatic logic [31:0] random_part(input int scale);
    case (scale)
      0: return $urandom;
      1: return 32'($urandom_range(131070) - 65535);
      default: begin
        case ($urandom_range(4))
          0: return FIELD_MIN;
          1: return FIELD_MAX;
          2: return 32'hFFFF_FFFF;
          3: return 32'd1;
          default: return 32'd0;
        endcase
      end
    endcase
  endfunction

  // Bins cluster on the band edges and a few hot entries so histories build up
  function automatic sample_t random_bin();
    int          r;
    int          scale;
    logic [8:0]  b;
    r = $urandom_range(99);
    if (r < 8) b = 9'($urandom_range(511, LAST_BIN + 1));
    else if (r < 13) b = 9'd0;
    else if (r < 25) b = 9'($urandom_range(511));
    else if (r < 40) begin
      case ($urandom_range(3))
        0: b = band_lo_q;
        1: b = band_hi_q;
        2: b = band_lo_q - 9'd1;
        default: b = band_hi_q + 9'd1;
      endcase
    end else if (r < 70) b = 9'($urandom_range(8, 1));
    else b = 9'($urandom_range(LAST_BIN));
    r = $urandom_range(99);
    scale = (r < 45) ? 0 : (r < 85) ? 1 : 2;
    return make_bin(b, random_part(scale), random_part(scale), random_part(scale),
                    random_part(scale));
  endfunction

  function automatic logic [THR_W-1:0] random_threshold();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return w[62:0];
      1: return '0;
      2: return 63'h4000_0000_0000_0000;
      3: return '1;
      default: return 63'(w >> $urandom_range(63, 20));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return 23'd4194304;
      2: return '1;
      3: return 23'($urandom);
      default: return 23'($urandom_range(4194304));
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] random_speed();
    case ($urandom_range(7))
      0: return '0;
      1: return 17'd1;
      2: return SPEED_MAX;
      3: return '1;
      4: return 17'($urandom);
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // Drop push and hold until every expected word has come back
  task automatic wait_idle();
    @(negedge clk);
    push = 1'b0;
    while (expected_gains.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [THR_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_POWER_THRESHOLD: thr_q = val;
      REG_BELOW_GAIN:      below_q = val[GAIN_W-1:0];
      REG_ABOVE_GAIN:      above_q = val[GAIN_W-1:0];
      REG_BAND_LOW_BIN:    band_lo_q = val[BIN_W-1:0];
      REG_BAND_HIGH_BIN:   band_hi_q = val[BIN_W-1:0];
      REG_SMOOTH_SPEED:    speed_q = val[SPEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Send one bin word; predict it at the edge it is taken
  task automatic send_bin(input sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push = 1'b1;
    in_word = s;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_gains.push_back(predict_gain(s));
  endtask

  // Drive pop with random stalls
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop = 1'b0;
      pop_hold--;
    end else begin
      pop = 1'b1;
      pop_hold = pick_gap();
    end
  end

  // Score each accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_gains.size() == 0) begin
        $display("%0t: unexpected word gain_out %0d bin_out %0d", $time,
                 out_word.gain_out, out_word.bin_out);
        mismatch_count++;
      end else begin
        want_word = expected_gains.pop_front();
        if (out_word.gain_out !== want_word.gain_out) begin
          $display("%0t: gain_out expected %0d actual %0d (bin %0d)", $time,
                   want_word.gain_out, out_word.gain_out, want_word.bin_out);
          mismatch_count++;
        end
        if (out_word.bin_out !== want_word.bin_out) begin
          $display("%0t: bin_out expected %0d actual %0d", $time,
                   want_word.bin_out, out_word.bin_out);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_bin(make_bin(9'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_bin(make_bin(9'd1, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    send_bin(make_bin(9'd256, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    send_bin(make_bin(9'd257, 32'd0, 32'd0, 32'd0, 32'd0));
    send_bin(make_bin(9'd511, 32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFFF, 32'h5555_AAAA));
  endtask

  // Power at both ends, including the sum that wraps to zero
  task automatic test_threshold_edges();
    write_reg(REG_POWER_THRESHOLD, 63'h4000_0000_0000_0000);
    write_reg(REG_BELOW_GAIN, 63'd0);
    write_reg(REG_ABOVE_GAIN, 63'd4194304);
    send_bin(make_bin(9'd5, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    send_bin(make_bin(9'd6, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    send_bin(make_bin(9'd7, 32'd0, 32'd0, 32'd0, 32'd0));
    write_reg(REG_POWER_THRESHOLD, '1);
    write_reg(REG_BELOW_GAIN, 63'h7F_FFFF);
    send_bin(make_bin(9'd6, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    send_bin(make_bin(9'd8, FIELD_MAX, FIELD_MIN, 32'd1, 32'hFFFF_FFFF));
  endtask

  // Out-of-range band limits clamp; crossed limits leave no gated bin
  task automatic test_band_limits();
    write_reg(REG_BAND_LOW_BIN, 63'd0);
    write_reg(REG_BAND_HIGH_BIN, 63'd511);
    send_bin(make_bin(9'd1, 32'd3, 32'd4, 32'd5, 32'd6));
    send_bin(make_bin(9'd256, FIELD_MAX, 32'd0, 32'd0, 32'd0));
    write_reg(REG_BAND_LOW_BIN, 63'd200);
    write_reg(REG_BAND_HIGH_BIN, 63'd100);
    send_bin(make_bin(9'd150, FIELD_MAX, FIELD_MAX, 32'd0, 32'd0));
    send_bin(make_bin(9'd200, 32'd0, 32'd0, 32'd0, 32'd0));
    send_bin(make_bin(9'd100, FIELD_MIN, 32'd0, 32'd0, 32'd0));
  endtask

  // Speed above unity saturates; zero speed holds the history
  task automatic test_speed_limits();
    write_reg(REG_BAND_LOW_BIN, 63'd1);
    write_reg(REG_BAND_HIGH_BIN, 63'd256);
    write_reg(REG_SMOOTH_SPEED, 63'h1_FFFF);
    send_bin(make_bin(9'd9, FIELD_MAX, 32'd0, 32'd0, 32'd0));
    write_reg(REG_SMOOTH_SPEED, 63'd0);
    send_bin(make_bin(9'd9, 32'd0, 32'd0, 32'd0, 32'd0));
    send_bin(make_bin(9'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    write_reg(REG_SMOOTH_SPEED, 63'd1);
    send_bin(make_bin(9'd9, 32'd0, 32'd0, 32'd0, 32'd0));
  endtask

  // Bins past the last leave the history alone
  task automatic test_bin_beyond_last();
    write_reg(REG_SMOOTH_SPEED, 63'd32768);
    send_bin(make_bin(9'd300, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX));
    send_bin(make_bin(9'd9, FIELD_MAX, 32'd0, 32'd0, 32'd0));
  endtask

  // Random settings per phase, random bins within each
  task automatic test_random_phases();
    int n;
    for (int phase = 0; phase < 10; phase++) begin
      idle_on = ($urandom_range(3) != 0);
      if (phase == 0) begin
        write_reg(REG_POWER_THRESHOLD, '1);
        write_reg(REG_BELOW_GAIN, '1);
        write_reg(REG_ABOVE_GAIN, 63'd4194304);
        write_reg(REG_BAND_LOW_BIN, 63'd256);
        write_reg(REG_BAND_HIGH_BIN, 63'd256);
        write_reg(REG_SMOOTH_SPEED, 63'd65536);
      end else if (phase == 1) begin
        write_reg(REG_POWER_THRESHOLD, 63'd0);
        write_reg(REG_BELOW_GAIN, 63'd0);
        write_reg(REG_ABOVE_GAIN, 63'd0);
        write_reg(REG_BAND_LOW_BIN, 63'd0);
        write_reg(REG_BAND_HIGH_BIN, 63'd0);
        write_reg(REG_SMOOTH_SPEED, 63'd0);
      end else begin
        write_reg(REG_POWER_THRESHOLD, random_threshold());
        write_reg(REG_BELOW_GAIN, 63'(random_gain()));
        write_reg(REG_ABOVE_GAIN, 63'(random_gain()));
        write_reg(REG_BAND_LOW_BIN, 63'(($urandom_range(9) == 0) ? $urandom_range(511)
                                                                   : $urandom_range(128)));
        write_reg(REG_BAND_HIGH_BIN, 63'(($urandom_range(9) == 0) ? $urandom_range(511)
                                                                    : $urandom_range(256, 64)));
        write_reg(REG_SMOOTH_SPEED, 63'(random_speed()));
      end
      n = $urandom_range(160, 100);
      repeat (n) send_bin(random_bin());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    thr_q = '0;
    below_q = '0;
    above_q = UNITY_Q16;
    band_lo_q = '0;
    band_hi_q = 9'd256;
    speed_q = SPEED_MAX;
    for (int k = 0; k <= LAST_BIN; k++) gain_track[k] = UNITY_Q16;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_threshold_edges();
    test_band_limits();
    test_speed_limits();
    test_bin_beyond_last();
    test_random_phases();

    // Drain, then let the pipeline settle
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_gains.size() == 0) begin
      $display("spectral_gate_gain_smoother: match");
    end else begin
      $display("spectral_gate_gain_smoother: mismatch");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("spectral_gate_gain_smoother: mismatch");
    $finish;
  end

endmodule

FILE: spectral_gate_gain_smoother.f
+incdir+rtl
rtl/sgg_pkg.sv
rtl/sgg_ram.sv
rtl/sgg_fifo.sv
rtl/sgg_front.sv
rtl/sgg_back.sv
rtl/spectral_gate_gain_smoother.sv
dv/spectral_gate_gain_smoother_test.sv
